// ----- hdl/oaid_pkg.sv -----
// ----------------------------------------------------------------------------
// oaid_pkg
// Types and codes shared by the ordered array insert/delete block.
// ----------------------------------------------------------------------------
package oaid_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_W   = 7;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_EDIT   = 3'd2,
    OP_DELETE = 3'd3,
    OP_GET    = 3'd4,
    OP_FIND   = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic shift_up;    // cells above the index take their lower neighbour
    logic shift_down;  // cells at and above the index take their upper neighbour
    logic write;       // cell at the index loads the new word
  } cell_ctrl_t;

endpackage

// ----- hdl/oaid_if.sv -----
// ----------------------------------------------------------------------------
// oaid_if
// Handshake channels of the ordered array block: request, result, config.
// ----------------------------------------------------------------------------
interface oaid_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [oaid_pkg::OP_W-1:0]            op;
  logic [oaid_pkg::POS_W-1:0]           position;
  logic signed [oaid_pkg::WORD_W-1:0]   word_in;

  modport source (output valid, op, position, word_in, input ready);
  modport sink   (input valid, op, position, word_in, output ready);
endinterface

interface oaid_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [oaid_pkg::STAT_W-1:0]          status;
  logic signed [oaid_pkg::WORD_W-1:0]   word_out;
  logic [oaid_pkg::POS_W-1:0]           found_at;
  logic [oaid_pkg::CNT_OUT_W-1:0]       item_count;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, status, word_out, found_at, item_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, word_out, found_at, item_count, is_empty, is_full,
                  output ready);
endinterface

interface oaid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [oaid_pkg::CAP_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/ordered_array_insert_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_array_insert_delete
// Packed list of signed words held in a chain of shifting cells.
//
//   channel  dir  fields
//   req      in   op, position, word_in
//   rsp      out  status, word_out, found_at, item_count, is_empty, is_full
//   cfg      in   data (capacity in use)
//
// The cells update and the match vector is registered at the accept edge; the
// first-match encode and result build feed the output register. A stalled
// result holds the item in the stage, and no new item is taken until it moves.
// Reset clears the count and the capacity to 64; the cells need no clearing.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  oaid_req_if.sink         req,
  oaid_rsp_if.source       rsp,
  oaid_cfg_if.sink         cfg
);
  import oaid_pkg::*;

  localparam int CW_RAW = $clog2(DEPTH + 1);
  localparam int CNT_W  = (CW_RAW > POS_W) ? CW_RAW : POS_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  pos_x;
  logic              full;
  logic              accept;

  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  idx;
  status_t           st_next;
  logic              rd_take;
  logic              is_find;

  logic [WORD_W-1:0] cell_q  [DEPTH];
  logic [WORD_W-1:0] rd_part [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [WORD_W-1:0] rd_bus;

  // stage between accept and result
  logic              s1_valid;
  status_t           s1_status;
  logic              s1_find;
  logic [WORD_W-1:0] s1_word;
  logic [DEPTH-1:0]  s1_hits;
  logic              s1_move;

  logic              hit_any;
  logic [POS_W-1:0]  hit_pos;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [WORD_W-1:0] out_word;
  logic [POS_W-1:0]  out_found;
  logic [CNT_W-1:0]  out_count;
  logic              out_full;

  assign cfg.ready = 1'b1;
  assign req.ready = !s1_valid;
  assign accept    = req.valid && req.ready;
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(capacity) > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign pos_x = CNT_W'(req.position);
  assign full  = count >= cap_eff;

  always_comb begin
    ctrl       = '0;
    idx        = pos_x;
    st_next    = ST_OK;
    rd_take    = 1'b0;
    is_find    = 1'b0;
    count_next = count;
    case (req.op)
      OP_APPEND: begin
        idx = count;
        if (full) begin
          st_next = ST_OVERFLOW;
        end else begin
          ctrl.write = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // index checked before capacity
        if (pos_x > count) begin
          st_next = ST_BAD_INDEX;
        end else if (full) begin
          st_next = ST_OVERFLOW;
        end else begin
          ctrl.shift_up = 1'b1;
          ctrl.write    = 1'b1;
          count_next    = count + CNT_W'(1);
        end
      end
      OP_EDIT: begin
        if (pos_x >= count) begin
          st_next = ST_BAD_INDEX;
        end else begin
          ctrl.write = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_x >= count) begin
          st_next = ST_BAD_INDEX;
        end else begin
          ctrl.shift_down = 1'b1;
          count_next      = count - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (pos_x >= count) begin
          st_next = ST_BAD_INDEX;
        end else begin
          rd_take = 1'b1;
        end
      end
      OP_FIND: begin
        is_find = 1'b1;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl       = '0;
      count_next = count;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    oaid_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .idx     (idx),
      .rd_idx  (pos_x),
      .count   (count),
      .word    (req.word_in),
      .lower   (cell_q[(g > 0) ? g - 1 : g]),
      .upper   (cell_q[(g < DEPTH - 1) ? g + 1 : g]),
      .data    (cell_q[g]),
      .rd_part (rd_part[g]),
      .match   (match[g])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_part[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st_next;
      s1_find   <= is_find;
      s1_word   <= rd_take ? rd_bus : '0;
      s1_hits   <= is_find ? match : '0;
    end
  end

  oaid_first_match #(
    .DEPTH (DEPTH)
  ) u_first (
    .hits     (s1_hits),
    .found    (hit_any),
    .found_at (hit_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // count is already final once the item has left the accept stage
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status <= s1_find ? (hit_any ? ST_OK : ST_NOT_FOUND) : s1_status;
      out_word   <= s1_word;
      out_found  <= hit_pos;
      out_count  <= count;
      out_full   <= count >= cap_eff;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.word_out   = out_word;
  assign rsp.found_at   = out_found;
  assign rsp.item_count = out_count[CNT_OUT_W-1:0];
  assign rsp.is_empty   = (out_count == '0);
  assign rsp.is_full    = out_full;

endmodule

// ----- hdl/oaid_cell.sv -----
// ----------------------------------------------------------------------------
// oaid_cell
// One slot of the list: holds a word, shifts with its neighbours, compares.
// ----------------------------------------------------------------------------
module oaid_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  oaid_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  idx,
  input  logic [CNT_W-1:0]                  rd_idx,
  input  logic [CNT_W-1:0]                  count,
  input  logic [oaid_pkg::WORD_W-1:0]       word,
  input  logic [oaid_pkg::WORD_W-1:0]       lower,
  input  logic [oaid_pkg::WORD_W-1:0]       upper,
  output logic [oaid_pkg::WORD_W-1:0]       data,
  output logic [oaid_pkg::WORD_W-1:0]       rd_part,
  output logic                              match
);
  import oaid_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [WORD_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.shift_down && (MY_IDX >= idx)) begin
      data_next = upper;
    end else if (ctrl.write && (MY_IDX == idx)) begin
      data_next = word;
    end else if (ctrl.shift_up && (MY_IDX > idx)) begin
      data_next = lower;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign rd_part = (MY_IDX == rd_idx) ? data : '0;
  assign match   = (MY_IDX < count) && (data == word);

endmodule

// ----- hdl/oaid_first_match.sv -----
// ----------------------------------------------------------------------------
// oaid_first_match
// Lowest set bit of the registered match vector, as a one-based position.
// ----------------------------------------------------------------------------
module oaid_first_match #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0]               hits,
  output logic                           found,
  output logic [oaid_pkg::POS_W-1:0]     found_at
);
  import oaid_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] lowest;
  logic [IDX_W-1:0] hit_idx;

  // isolate the lowest set bit, then encode it by OR
  assign lowest = hits & (~hits + DEPTH'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign found    = |hits;
  assign found_at = found ? POS_W'({1'b0, hit_idx} + (IDX_W+1)'(1)) : '0;

endmodule

// ----- hdl/oaid_checker.sv -----
// ----------------------------------------------------------------------------
// oaid_checker
// Port-level checks on the result channel of the ordered array block.
// ----------------------------------------------------------------------------
module oaid_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [oaid_pkg::STAT_W-1:0]        status,
  input logic [oaid_pkg::WORD_W-1:0]        word_out,
  input logic [oaid_pkg::POS_W-1:0]         found_at,
  input logic [oaid_pkg::CNT_OUT_W-1:0]     item_count,
  input logic                               is_empty
);
  import oaid_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(word_out))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (item_count == '0)))
    else $error("empty flag disagrees with count");

  a_notfound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (found_at == '0) && (word_out == '0))
    else $error("failed item carries a word or position");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (found_at != '0) |-> (found_at <= item_count))
    else $error("match position beyond the list");

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .word_out   (rsp.word_out),
  .found_at   (rsp.found_at),
  .item_count (rsp.item_count),
  .is_empty   (rsp.is_empty)
);
